>>> hdl/fbct_pkg.sv
// Shared constants for the frustum box cull test.
`timescale 1ns / 1ps

package fbct_pkg;

  localparam int IN_W      = 32;
  localparam int HALF_IN_W = 31;
  localparam int IDX_W     = 3;
  localparam int PLANE_COUNT = 6;
  localparam int AXIS_COUNT  = 3;

  localparam logic [IDX_W-1:0] PLANE_LIMIT = IDX_W'(PLANE_COUNT);

  localparam logic KIND_TEST = 1'b0;
  localparam logic KIND_LOAD = 1'b1;

endpackage

>>> hdl/frustum_box_cull_test.sv
// Pipelined test of an axis-aligned box against six stored frustum planes.
//
// Usage: one input channel carries both kinds of item. An item is taken at a
// rising edge where start is high and busy is low; busy is always low, so an
// item can enter in every cycle. A load item writes one plane slot at that
// edge and gives no result; a load to slot six or seven is dropped. A test
// item gives exactly one result: out_valid is high for one cycle together
// with out_intersects, driven from the last of five register stages. The
// first is loaded at the accepting edge; in order they are operand setup,
// multiply, partial sums, final sum and sign, plane reduce. Throughput is
// one item per cycle.
// A test sees every load accepted before it and none accepted after it.
// The receiver cannot stall; results leave in order, one per cycle at most.
// Synchronous reset clears all six planes to zero and drops items in flight.
// A box tested against a zero plane is always culled.
`timescale 1ns / 1ps

module frustum_box_cull_test #(
  parameter int VALUE_WIDTH   = 32,
  parameter int FRACTION_BITS = 16
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  output logic                           busy,
  input  logic                           in_kind,
  input  logic [fbct_pkg::IDX_W-1:0]     in_plane_index,
  input  logic signed [fbct_pkg::IN_W-1:0] in_plane_a,
  input  logic signed [fbct_pkg::IN_W-1:0] in_plane_b,
  input  logic signed [fbct_pkg::IN_W-1:0] in_plane_c,
  input  logic signed [fbct_pkg::IN_W-1:0] in_plane_offset,
  input  logic signed [fbct_pkg::IN_W-1:0] in_center_x,
  input  logic signed [fbct_pkg::IN_W-1:0] in_center_y,
  input  logic signed [fbct_pkg::IN_W-1:0] in_center_z,
  input  logic [fbct_pkg::HALF_IN_W-1:0] in_half_x,
  input  logic [fbct_pkg::HALF_IN_W-1:0] in_half_y,
  input  logic [fbct_pkg::HALF_IN_W-1:0] in_half_z,
  output logic                           out_valid,
  output logic                           out_intersects
);

  import fbct_pkg::*;

  localparam int SB    = (VALUE_WIDTH < IN_W) ? VALUE_WIDTH : IN_W;
  localparam int HB    = SB - 1;
  localparam int E_W   = SB + 2;
  localparam int P_W   = 2 * SB + 2;
  localparam int ACC_A = 2 * SB + 4;
  localparam int ACC_B = SB + FRACTION_BITS + 2;
  localparam int ACC_W = (ACC_A > ACC_B) ? ACC_A : ACC_B;

  logic signed [SB-1:0] nrm_x_r [PLANE_COUNT];
  logic signed [SB-1:0] nrm_y_r [PLANE_COUNT];
  logic signed [SB-1:0] nrm_z_r [PLANE_COUNT];
  logic signed [SB-1:0] ofs_r   [PLANE_COUNT];

  logic accept;
  logic load_en;

  logic signed [SB-1:0] ctr [AXIS_COUNT];
  logic [HB-1:0]        hlf [AXIS_COUNT];

  logic                  s1_vld_r;
  logic signed [SB-1:0]  s1_a_r   [PLANE_COUNT][AXIS_COUNT];
  logic signed [E_W-1:0] s1_e_r   [PLANE_COUNT][AXIS_COUNT];
  logic signed [SB-1:0]  s1_d_r   [PLANE_COUNT];
  logic signed [SB-1:0]  s1_a_nxt [PLANE_COUNT][AXIS_COUNT];
  logic signed [E_W-1:0] s1_e_nxt [PLANE_COUNT][AXIS_COUNT];
  logic signed [SB-1:0]  s1_d_nxt [PLANE_COUNT];

  logic                    s2_vld_r;
  logic signed [P_W-1:0]   s2_p_r   [PLANE_COUNT][AXIS_COUNT];
  logic signed [ACC_W-1:0] s2_d_r   [PLANE_COUNT];
  logic signed [P_W-1:0]   s2_p_nxt [PLANE_COUNT][AXIS_COUNT];
  logic signed [ACC_W-1:0] s2_d_nxt [PLANE_COUNT];

  logic                    s3_vld_r;
  logic signed [ACC_W-1:0] s3_lo_r  [PLANE_COUNT];
  logic signed [ACC_W-1:0] s3_hi_r  [PLANE_COUNT];
  logic signed [ACC_W-1:0] s3_lo_nxt [PLANE_COUNT];
  logic signed [ACC_W-1:0] s3_hi_nxt [PLANE_COUNT];

  logic                   s4_vld_r;
  logic [PLANE_COUNT-1:0] s4_pass_r;
  logic [PLANE_COUNT-1:0] s4_pass_nxt;
  logic signed [ACC_W-1:0] s4_sum [PLANE_COUNT];

  logic out_valid_r;
  logic out_intersects_r;

  assign busy    = 1'b0;
  assign accept  = start && !busy;
  assign load_en = accept && (in_kind == KIND_LOAD) && (in_plane_index < PLANE_LIMIT);

  assign ctr[0] = in_center_x[SB-1:0];
  assign ctr[1] = in_center_y[SB-1:0];
  assign ctr[2] = in_center_z[SB-1:0];
  assign hlf[0] = in_half_x[HB-1:0];
  assign hlf[1] = in_half_y[HB-1:0];
  assign hlf[2] = in_half_z[HB-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < PLANE_COUNT; i++) begin
        nrm_x_r[i] <= '0;
        nrm_y_r[i] <= '0;
        nrm_z_r[i] <= '0;
        ofs_r[i]   <= '0;
      end
    end else if (load_en) begin
      nrm_x_r[in_plane_index] <= in_plane_a[SB-1:0];
      nrm_y_r[in_plane_index] <= in_plane_b[SB-1:0];
      nrm_z_r[in_plane_index] <= in_plane_c[SB-1:0];
      ofs_r[in_plane_index]   <= in_plane_offset[SB-1:0];
    end
  end

  // The term a*c - |a|*h equals a*(c - h) for a >= 0 and a*(c + h) for a < 0.
  always_comb begin
    for (int i = 0; i < PLANE_COUNT; i++) begin
      s1_a_nxt[i][0] = nrm_x_r[i];
      s1_a_nxt[i][1] = nrm_y_r[i];
      s1_a_nxt[i][2] = nrm_z_r[i];
      s1_d_nxt[i]    = ofs_r[i];
      for (int k = 0; k < AXIS_COUNT; k++) begin
        if (s1_a_nxt[i][k][SB-1]) begin
          s1_e_nxt[i][k] = E_W'(ctr[k]) + $signed({{(E_W-HB){1'b0}}, hlf[k]});
        end else begin
          s1_e_nxt[i][k] = E_W'(ctr[k]) - $signed({{(E_W-HB){1'b0}}, hlf[k]});
        end
      end
    end
  end

  always_comb begin
    for (int i = 0; i < PLANE_COUNT; i++) begin
      s2_d_nxt[i] = ACC_W'(s1_d_r[i]) <<< FRACTION_BITS;
      for (int k = 0; k < AXIS_COUNT; k++) begin
        s2_p_nxt[i][k] = P_W'(s1_a_r[i][k]) * P_W'(s1_e_r[i][k]);
      end
    end
  end

  always_comb begin
    for (int i = 0; i < PLANE_COUNT; i++) begin
      s3_lo_nxt[i] = s2_d_r[i] + ACC_W'(s2_p_r[i][0]);
      s3_hi_nxt[i] = ACC_W'(s2_p_r[i][1]) + ACC_W'(s2_p_r[i][2]);
    end
  end

  always_comb begin
    for (int i = 0; i < PLANE_COUNT; i++) begin
      s4_sum[i]      = s3_lo_r[i] + s3_hi_r[i];
      s4_pass_nxt[i] = s4_sum[i][ACC_W-1];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r    <= 1'b0;
      s2_vld_r    <= 1'b0;
      s3_vld_r    <= 1'b0;
      s4_vld_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_vld_r    <= accept && (in_kind == KIND_TEST);
      s2_vld_r    <= s1_vld_r;
      s3_vld_r    <= s2_vld_r;
      s4_vld_r    <= s3_vld_r;
      out_valid_r <= s4_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    s1_a_r           <= s1_a_nxt;
    s1_e_r           <= s1_e_nxt;
    s1_d_r           <= s1_d_nxt;
    s2_p_r           <= s2_p_nxt;
    s2_d_r           <= s2_d_nxt;
    s3_lo_r          <= s3_lo_nxt;
    s3_hi_r          <= s3_hi_nxt;
    s4_pass_r        <= s4_pass_nxt;
    out_intersects_r <= &s4_pass_r;
  end

  assign out_valid      = out_valid_r;
  assign out_intersects = out_intersects_r;

endmodule

>>> tb/tb_top.sv
// Self-checking testbench for the frustum box cull test block.
`timescale 1ns / 1ps

module tb_top;
  import fbct_pkg::*;

  localparam int FRAC = 16;
  localparam int RANDOM_ITEMS = 1050;
  localparam int CYCLE_LIMIT = 400000;
  localparam int REPORT_MAX = 10;

  localparam logic [IDX_W-1:0] SLOT_RIGHT  = 3'd0;
  localparam logic [IDX_W-1:0] SLOT_LEFT   = 3'd1;
  localparam logic [IDX_W-1:0] SLOT_TOP    = 3'd2;
  localparam logic [IDX_W-1:0] SLOT_BOTTOM = 3'd3;
  localparam logic [IDX_W-1:0] SLOT_NEAR   = 3'd4;
  localparam logic [IDX_W-1:0] SLOT_FAR    = 3'd5;
  localparam logic [IDX_W-1:0] SLOT_SPARE0 = 3'd6;
  localparam logic [IDX_W-1:0] SLOT_SPARE1 = 3'd7;

  localparam logic signed [IN_W-1:0] ONE  = 32'sh0001_0000;
  localparam logic signed [IN_W-1:0] MAXP = 32'sh7fff_ffff;
  localparam logic signed [IN_W-1:0] MINN = 32'sh8000_0000;
  localparam logic [HALF_IN_W-1:0]   HMAX = 31'h7fff_ffff;

  typedef struct {
    logic                   kind;
    logic [IDX_W-1:0]       slot;
    logic signed [IN_W-1:0] nx, ny, nz, offset;
    logic signed [IN_W-1:0] cx, cy, cz;
    logic [HALF_IN_W-1:0]   hx, hy, hz;
  } cull_item_t;

  class cull_scoreboard;
    logic signed [IN_W-1:0] norm_x[PLANE_COUNT], norm_y[PLANE_COUNT];
    logic signed [IN_W-1:0] norm_z[PLANE_COUNT], offs[PLANE_COUNT];
    bit verdict_q[$];
    int unsigned errors, loads, tests, kept, culled;

    function new();
      for (int p = 0; p < PLANE_COUNT; p++) begin
        norm_x[p] = '0;
        norm_y[p] = '0;
        norm_z[p] = '0;
        offs[p] = '0;
      end
    endfunction

    function bit box_meets_plane(int p, cull_item_t it);
      logic signed [127:0] acc, nrm, mag, ctr, hw;
      logic signed [IN_W-1:0] n[AXIS_COUNT], c[AXIS_COUNT];
      logic [HALF_IN_W-1:0] h[AXIS_COUNT];
      n[0] = norm_x[p]; n[1] = norm_y[p]; n[2] = norm_z[p];
      c[0] = it.cx; c[1] = it.cy; c[2] = it.cz;
      h[0] = it.hx; h[1] = it.hy; h[2] = it.hz;
      acc = offs[p];
      acc = acc <<< FRAC;
      for (int k = 0; k < AXIS_COUNT; k++) begin
        nrm = n[k];
        ctr = c[k];
        hw = {97'b0, h[k]};
        mag = (nrm < 0) ? -nrm : nrm;
        acc = acc + nrm * ctr - mag * hw;
      end
      return acc < 0;
    endfunction

    function void note_item(cull_item_t it);
      bit all_pass;
      if (it.kind == KIND_LOAD) begin
        loads++;
        if (it.slot < PLANE_LIMIT) begin
          norm_x[it.slot] = it.nx;
          norm_y[it.slot] = it.ny;
          norm_z[it.slot] = it.nz;
          offs[it.slot] = it.offset;
        end
      end else begin
        tests++;
        all_pass = 1'b1;
        for (int p = 0; p < PLANE_COUNT; p++)
          if (!box_meets_plane(p, it)) all_pass = 1'b0;
        verdict_q.push_back(all_pass);
      end
    endfunction

    function void check_result(logic got);
      bit want;
      if (got === 1'b1) kept++;
      else culled++;
      if (verdict_q.size() == 0) begin
        errors++;
        if (errors <= REPORT_MAX)
          $display("Unexpected result: intersects=%b with no box test pending.", got);
        return;
      end
      want = verdict_q.pop_front();
      if (got !== want) begin
        errors++;
        if (errors <= REPORT_MAX)
          $display("Mismatch on box test %0d: expected intersects=%b, got %b.",
                   kept + culled, want, got);
      end
    endfunction

    function int pending();
      return verdict_q.size();
    endfunction
  endclass

  logic clk, rst_n, start, busy;
  logic in_kind;
  logic [IDX_W-1:0] in_plane_index;
  logic signed [IN_W-1:0] in_plane_a, in_plane_b, in_plane_c, in_plane_offset;
  logic signed [IN_W-1:0] in_center_x, in_center_y, in_center_z;
  logic [HALF_IN_W-1:0] in_half_x, in_half_y, in_half_z;
  logic out_valid, out_intersects;

  cull_scoreboard sb = new();
  int unsigned cycle_count = 0;
  int burst_left = 0;

  frustum_box_cull_test dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_kind(in_kind), .in_plane_index(in_plane_index),
    .in_plane_a(in_plane_a), .in_plane_b(in_plane_b), .in_plane_c(in_plane_c),
    .in_plane_offset(in_plane_offset),
    .in_center_x(in_center_x), .in_center_y(in_center_y), .in_center_z(in_center_z),
    .in_half_x(in_half_x), .in_half_y(in_half_y), .in_half_z(in_half_z),
    .out_valid(out_valid), .out_intersects(out_intersects)
  );

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Run stopped after %0d cycles without draining.", cycle_count);
      $display("CHECKS FAILED");
      $finish;
    end
  end

  always @(posedge clk)
    if (rst_n && out_valid) sb.check_result(out_intersects);

  function automatic cull_item_t random_fill();
    cull_item_t it;
    it.kind = 1'($urandom_range(0, 1));
    it.slot = IDX_W'($urandom_range(0, 7));
    it.nx = $urandom;
    it.ny = $urandom;
    it.nz = $urandom;
    it.offset = $urandom;
    it.cx = $urandom;
    it.cy = $urandom;
    it.cz = $urandom;
    it.hx = HALF_IN_W'($urandom);
    it.hy = HALF_IN_W'($urandom);
    it.hz = HALF_IN_W'($urandom);
    return it;
  endfunction

  function automatic cull_item_t mk_load(logic [IDX_W-1:0] slot, logic signed [IN_W-1:0] a,
                                         logic signed [IN_W-1:0] b, logic signed [IN_W-1:0] c,
                                         logic signed [IN_W-1:0] d);
    cull_item_t it;
    it = random_fill();
    it.kind = KIND_LOAD;
    it.slot = slot;
    it.nx = a;
    it.ny = b;
    it.nz = c;
    it.offset = d;
    return it;
  endfunction

  function automatic cull_item_t mk_test(logic signed [IN_W-1:0] cx, logic signed [IN_W-1:0] cy,
                                         logic signed [IN_W-1:0] cz, logic [HALF_IN_W-1:0] hx,
                                         logic [HALF_IN_W-1:0] hy, logic [HALF_IN_W-1:0] hz);
    cull_item_t it;
    it = random_fill();
    it.kind = KIND_TEST;
    it.cx = cx;
    it.cy = cy;
    it.cz = cz;
    it.hx = hx;
    it.hy = hy;
    it.hz = hz;
    return it;
  endfunction

  // A plane bounding one face of a slab of half width lim, slightly tilted.
  function automatic cull_item_t make_plane(int slot, int scale, int lim);
    int comp[AXIS_COUNT];
    longint ofs_val;
    for (int k = 0; k < AXIS_COUNT; k++) begin
      comp[k] = $urandom_range(0, scale / 8);
      if ($urandom_range(0, 1)) comp[k] = -comp[k];
    end
    comp[slot / 2] = (slot % 2) ? -scale : scale;
    ofs_val = (longint'(scale) * longint'(lim)) >>> FRAC;
    return mk_load(IDX_W'(slot), comp[0], comp[1], comp[2], -int'(ofs_val));
  endfunction

  function automatic cull_item_t make_box(int lim);
    if ($urandom_range(0, 9) == 0) return mk_test($urandom, $urandom, $urandom,
                                                  HALF_IN_W'($urandom), HALF_IN_W'($urandom),
                                                  HALF_IN_W'($urandom));
    return mk_test(int'($urandom_range(0, 4 * lim)) - 2 * lim,
                   int'($urandom_range(0, 4 * lim)) - 2 * lim,
                   int'($urandom_range(0, 4 * lim)) - 2 * lim,
                   HALF_IN_W'($urandom_range(0, lim)), HALF_IN_W'($urandom_range(0, lim)),
                   HALF_IN_W'($urandom_range(0, lim)));
  endfunction

  task automatic send_item(cull_item_t it);
    @(negedge clk);
    in_kind = it.kind;
    in_plane_index = it.slot;
    in_plane_a = it.nx;
    in_plane_b = it.ny;
    in_plane_c = it.nz;
    in_plane_offset = it.offset;
    in_center_x = it.cx;
    in_center_y = it.cy;
    in_center_z = it.cz;
    in_half_x = it.hx;
    in_half_y = it.hy;
    in_half_z = it.hz;
    start = 1'b1;
    @(posedge clk);
    while (busy) @(posedge clk);
    sb.note_item(it);
  endtask

  task automatic idle_cycles(int n);
    cull_item_t junk;
    for (int i = 0; i < n; i++) begin
      @(negedge clk);
      junk = random_fill();
      start = 1'b0;
      in_kind = junk.kind;
      in_plane_index = junk.slot;
      in_center_x = junk.cx;
      in_plane_a = junk.nx;
      in_half_x = junk.hx;
    end
  endtask

  task automatic put_item(cull_item_t it);
    if (burst_left == 0) begin
      idle_cycles($urandom_range(1, 8));
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(50, 200)
                                                : $urandom_range(1, 30);
    end
    burst_left--;
    send_item(it);
  endtask

  initial begin
    int scale, lim, n_tests, first_slot;
    int sent;
    rst_n = 1'b0;
    start = 1'b0;
    in_kind = KIND_TEST;
    in_plane_index = '0;
    in_plane_a = '0;
    in_plane_b = '0;
    in_plane_c = '0;
    in_plane_offset = '0;
    in_center_x = '0;
    in_center_y = '0;
    in_center_z = '0;
    in_half_x = '0;
    in_half_y = '0;
    in_half_z = '0;
    repeat (6) @(negedge clk);
    rst_n = 1'b1;

    // With the plane store still cleared, every box must be culled.
    put_item(mk_test(MAXP, MINN, 0, HMAX, HMAX, HMAX));
    put_item(mk_load(SLOT_RIGHT, ONE, 0, 0, -10 * ONE));
    put_item(mk_load(SLOT_LEFT, -ONE, 0, 0, -10 * ONE));
    put_item(mk_load(SLOT_TOP, 0, ONE, 0, -10 * ONE));
    put_item(mk_load(SLOT_BOTTOM, 0, -ONE, 0, -10 * ONE));
    put_item(mk_load(SLOT_NEAR, 0, 0, ONE, -10 * ONE));
    put_item(mk_load(SLOT_FAR, 0, 0, -ONE, -10 * ONE));
    put_item(mk_test(0, 0, 0, 0, 0, 0));
    put_item(mk_test(20 * ONE, 0, 0, ONE, ONE, ONE));
    // A box that only touches a plane is culled; one step further in it is kept.
    put_item(mk_test(11 * ONE, 0, 0, ONE, 0, 0));
    put_item(mk_test(11 * ONE, 0, 0, ONE + 1, 0, 0));
    put_item(mk_test(0, -11 * ONE, 0, 0, ONE, 0));
    put_item(mk_test(MINN, MAXP, MINN, HMAX, HMAX, HMAX));
    put_item(mk_test(MAXP, MAXP, MAXP, 0, 0, 0));
    // Loads to the two slots past the last plane must leave the store alone.
    put_item(mk_load(SLOT_SPARE0, 0, 0, 0, 0));
    put_item(mk_load(SLOT_SPARE1, MINN, MAXP, MINN, MAXP));
    put_item(mk_test(0, 0, 0, 0, 0, 0));
    put_item(mk_load(SLOT_RIGHT, MINN, MINN, MINN, MAXP));
    put_item(mk_test(MAXP, MAXP, MAXP, 0, 0, 0));
    put_item(mk_test(MINN, MINN, MINN, HMAX, HMAX, HMAX));
    put_item(mk_load(SLOT_LEFT, MAXP, MAXP, MAXP, MINN));
    put_item(mk_test(MINN, 0, MAXP, HMAX, 0, 1));
    put_item(mk_test(MAXP, MINN, MAXP, HMAX, HMAX, HMAX));

    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      if ($urandom_range(0, 4) == 0) begin
        n_tests = $urandom_range(5, 20);
        for (int i = 0; i < n_tests; i++) put_item(random_fill());
        sent += n_tests;
      end else begin
        scale = $urandom_range(1 << 12, 1 << 18);
        lim = $urandom_range(1 << 16, 1 << 24);
        first_slot = $urandom_range(0, PLANE_COUNT - 1);
        for (int j = 0; j < PLANE_COUNT; j++)
          put_item(make_plane((first_slot + j) % PLANE_COUNT, scale, lim));
        n_tests = $urandom_range(15, 40);
        for (int i = 0; i < n_tests; i++) begin
          case ($urandom_range(0, 15))
            0: put_item(make_plane($urandom_range(0, PLANE_COUNT - 1), scale, lim));
            1: put_item(mk_load(IDX_W'($urandom_range(PLANE_COUNT, 7)), $urandom, $urandom,
                                $urandom, $urandom));
            default: put_item(make_box(lim));
          endcase
        end
        sent += PLANE_COUNT + n_tests;
      end
    end

    @(negedge clk);
    start = 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (20) @(posedge clk);

    $display("Sent %0d plane loads and %0d box tests over %0d cycles.",
             sb.loads, sb.tests, cycle_count);
    $display("Results seen: %0d kept, %0d culled; %0d errors, %0d still pending.",
             sb.kept, sb.culled, sb.errors, sb.pending());
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
